@@ sv/assert_macros.svh @@
// assertion macros used by the one rtl file that checks itself, adrc_speed_loop_unit
// depends on nothing; taken in by `include
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, idle while reset is high
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// next-cycle implication, idle while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ sv/adrc_pkg.sv @@
// types, constants and helpers of the adrc speed loop
// no dependencies; used by adrc_mul, adrc_div and adrc_speed_loop_unit
package adrc_pkg;

   localparam int WHEELS_DEFAULT = 2;

   // register indexes on the csr port
   localparam logic [2:0] CSR_PLANT_GAIN   = 3'd0;
   localparam logic [2:0] CSR_OBS_GAIN_ONE = 3'd1;
   localparam logic [2:0] CSR_OBS_GAIN_TWO = 3'd2;
   localparam logic [2:0] CSR_LOOP_GAIN    = 3'd3;
   localparam logic [2:0] CSR_SAMPLE_PER   = 3'd4;
   localparam logic [2:0] CSR_DEAD_ZONE    = 3'd5;
   localparam logic [2:0] CSR_OUTPUT_LIMIT = 3'd6;

   // register reset values
   localparam logic [23:0] PLANT_GAIN_RST   = 24'd2048;
   localparam logic [23:0] OBS_GAIN_ONE_RST = 24'd48230;
   localparam logic [23:0] OBS_GAIN_TWO_RST = 24'd2271744;
   localparam logic [23:0] LOOP_GAIN_RST    = 24'd8038;
   localparam logic [15:0] SAMPLE_PER_RST   = 16'd655;
   localparam logic [14:0] DEAD_ZONE_RST    = 15'd0;
   localparam logic [14:0] OUTPUT_LIMIT_RST = 15'd10000;

   // largest magnitude of a q32.16 value
   localparam logic [47:0] SAT_MAG = 48'h7FFF_FFFF_FFFF;
   localparam logic signed [49:0] SAT_POS = 50'sh0_7FFF_FFFF_FFFF;
   localparam logic signed [49:0] SAT_NEG = -50'sh0_7FFF_FFFF_FFFF;

   // divider: quotient bits of (|v| << 8) / b0
   localparam int DIV_STEPS = 56;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   typedef struct packed {
      logic              wheel;
      logic signed [15:0] target_speed;
      logic signed [15:0] measured_speed;
   } req_type;

   typedef struct packed {
      logic              wheel_echo;
      logic signed [15:0] drive_out;
   } rsp_type;

   // command to the shared multiplier
   typedef struct packed {
      logic              start;
      logic              sh16;
      logic [23:0]       gain;
      logic signed [47:0] operand;
   } mul_cmd_type;

   // command to the divider
   typedef struct packed {
      logic                   start;
      logic                   neg;
      logic [DIV_STEPS-1:0]   num;
      logic [23:0]            den;
   } div_cmd_type;

   function automatic logic signed [49:0] ext50(input logic signed [47:0] v);
      ext50 = {{2{v[47]}}, v};
   endfunction

   // clamp to the symmetric 48-bit range
   function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
      logic signed [49:0] c;
      c = v;
      if (v > SAT_POS) c = SAT_POS;
      if (v < SAT_NEG) c = SAT_NEG;
      sat48 = c[47:0];
   endfunction

endpackage

@@ sv/adrc_mul.sv @@
// shared multiplier: signed q32.16 times unsigned gain in sign and magnitude, shifted by 8 or 16
// depends on adrc_pkg
module adrc_mul (
   input  logic                      clock,
   input  logic                      reset,
   input  adrc_pkg::mul_cmd_type     cmd,
   output logic signed [47:0]        result,
   output logic                      done
);

   logic [1:0]         cnt_ff, cnt_in;
   logic               neg_ff, neg_in;
   logic               sh16_ff, sh16_in;
   logic [47:0]        mag_ff, mag_in;
   logic [23:0]        gain_ff, gain_in;
   logic [47:0]        plo_ff, plo_in;
   logic [47:0]        phi_ff, phi_in;
   logic signed [47:0] res_ff, res_in;
   logic               done_ff, done_in;
   logic [71:0]        full;
   logic [63:0]        shifted;
   logic [47:0]        rmag;

   // recombine the partial products, shift and saturate the magnitude
   always_comb begin
      full    = {phi_ff, 24'd0} + {24'd0, plo_ff};
      shifted = sh16_ff ? {8'd0, full[71:16]} : full[71:8];
      rmag    = (shifted > {16'd0, adrc_pkg::SAT_MAG}) ? adrc_pkg::SAT_MAG : shifted[47:0];
   end

   // low half, high half, combine
   always_comb begin
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      sh16_in = sh16_ff;
      mag_in  = mag_ff;
      gain_in = gain_ff;
      plo_in  = plo_ff;
      phi_in  = phi_ff;
      res_in  = res_ff;
      done_in = 1'b0;
      case (cnt_ff)
         2'd0: begin
            if (cmd.start) begin
               neg_in  = cmd.operand[47];
               mag_in  = cmd.operand[47] ? -cmd.operand : cmd.operand;
               gain_in = cmd.gain;
               sh16_in = cmd.sh16;
               cnt_in  = 2'd1;
            end
         end
         2'd1: begin
            plo_in = mag_ff[23:0] * gain_ff;
            cnt_in = 2'd2;
         end
         2'd2: begin
            phi_in = mag_ff[47:24] * gain_ff;
            cnt_in = 2'd3;
         end
         default: begin
            res_in  = neg_ff ? -$signed(rmag) : $signed(rmag);
            done_in = 1'b1;
            cnt_in  = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 2'd0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      sh16_ff <= sh16_in;
      mag_ff  <= mag_in;
      gain_ff <= gain_in;
      plo_ff  <= plo_in;
      phi_ff  <= phi_in;
      res_ff  <= res_in;
   end

   assign result = res_ff;
   assign done   = done_ff;

endmodule

@@ sv/adrc_div.sv @@
// restoring divider, one quotient bit a cycle, result saturated to 48 bits
// depends on adrc_pkg
module adrc_div (
   input  logic                      clock,
   input  logic                      reset,
   input  adrc_pkg::div_cmd_type     cmd,
   output logic signed [47:0]        result,
   output logic                      done
);

   localparam int N = adrc_pkg::DIV_STEPS;
   localparam int CW = adrc_pkg::DIV_CNT_W;

   logic               run_ff, run_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               neg_ff, neg_in;
   logic [23:0]        den_ff, den_in;
   logic [23:0]        rem_ff, rem_in;
   logic [N-1:0]       quo_ff, quo_in;
   logic signed [47:0] res_ff, res_in;
   logic               done_ff, done_in;
   logic [24:0]        trial;
   logic [47:0]        qmag;

   always_comb begin
      trial = {rem_ff, quo_ff[N-1]} - {1'b0, den_ff};
      qmag  = (quo_ff > N'(adrc_pkg::SAT_MAG)) ? adrc_pkg::SAT_MAG : quo_ff[47:0];
   end

   // shift-subtract steps, then sign and saturate
   always_comb begin
      run_in  = run_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      res_in  = res_ff;
      done_in = 1'b0;
      if (!run_ff) begin
         if (cmd.start) begin
            run_in = 1'b1;
            cnt_in = CW'(N);
            neg_in = cmd.neg;
            den_in = cmd.den;
            rem_in = 24'd0;
            quo_in = cmd.num;
         end
      end else if (cnt_ff != '0) begin
         if (!trial[24]) begin
            rem_in = trial[23:0];
            quo_in = {quo_ff[N-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[22:0], quo_ff[N-1]};
            quo_in = {quo_ff[N-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
      end else begin
         res_in  = neg_ff ? -$signed(qmag) : $signed(qmag);
         done_in = 1'b1;
         run_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      res_ff <= res_in;
   end

   assign result = res_ff;
   assign done   = done_ff;

endmodule

@@ sv/adrc_speed_loop_unit.sv @@
// adrc speed loop: observer update and control law for several wheels
// depends on adrc_pkg, adrc_mul, adrc_div and assert_macros.svh
//
// usage:
//  - req channel (valid/ready) takes one control tick: wheel, target and
//    measured speed. rsp channel (valid/ready) gives the wheel and the drive.
//  - csr port writes gains, sample period, dead zone and limit; write only
//    while no tick is in flight. unknown indexes are dropped.
//  - the time of a tick from accept to rsp_valid is dominated by six
//    passes through the shared 24x24 multiplier and by the 56-step
//    restoring divider for the division by b0.
//  - req_ready is high only while the sequencer idles, so a new tick is
//    taken only once the last one has left the sequencer.
//  - the result sits in an output register; a new tick is taken while it
//    waits. if the receiver still stalls when the next result is done, the
//    sequencer holds in its last step until the old beat leaves.
//  - reset restores the register defaults and zeros every wheel's speed
//    estimate, disturbance estimate and last drive.
`include "assert_macros.svh"

module adrc_speed_loop_unit #(
   parameter int WHEELS = adrc_pkg::WHEELS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  adrc_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output adrc_pkg::rsp_type    rsp_data,
   input  logic                 csr_wr_en,
   input  logic [2:0]           csr_index,
   input  logic [23:0]          csr_wdata
);

   localparam int WIDX = (WHEELS > 1) ? $clog2(WHEELS) : 1;

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_ERR     = 5'd1;
   localparam logic [4:0] S_M_BETA1 = 5'd2;
   localparam logic [4:0] S_W_BETA1 = 5'd3;
   localparam logic [4:0] S_M_PLANT = 5'd4;
   localparam logic [4:0] S_W_PLANT = 5'd5;
   localparam logic [4:0] S_M_BETA2 = 5'd6;
   localparam logic [4:0] S_W_BETA2 = 5'd7;
   localparam logic [4:0] S_M_Z1    = 5'd8;
   localparam logic [4:0] S_W_Z1    = 5'd9;
   localparam logic [4:0] S_M_Z2    = 5'd10;
   localparam logic [4:0] S_W_Z2    = 5'd11;
   localparam logic [4:0] S_M_KP    = 5'd12;
   localparam logic [4:0] S_W_KP    = 5'd13;
   localparam logic [4:0] S_DIV     = 5'd14;
   localparam logic [4:0] S_W_DIV   = 5'd15;
   localparam logic [4:0] S_FIN     = 5'd16;

   // configuration
   logic [23:0] plant_gain_ff, obs_one_ff, obs_two_ff, loop_gain_ff;
   logic [15:0] period_ff;
   logic [14:0] dead_zone_ff, limit_ff;

   // per-wheel state
   logic signed [47:0] z1_mem_ff   [WHEELS];
   logic signed [47:0] z2_mem_ff   [WHEELS];
   logic signed [47:0] last_mem_ff [WHEELS];
   logic               we_est, we_last;

   // sequencer and working registers
   logic [4:0]         state_ff, state_in;
   logic               wheel_ff, wheel_in;
   logic [WIDX-1:0]    idx_ff, idx_in, req_idx;
   logic signed [15:0] r_ff, r_in, y_ff, y_in;
   logic signed [47:0] z1_ff, z1_in, z2_ff, z2_in, last_ff, last_in;
   logic signed [47:0] e_ff, e_in, acc_ff, acc_in, d1_ff, d1_in, d2_ff, d2_in;
   logic signed [47:0] z1n_ff, z1n_in, z2n_ff, z2n_in, u_ff, u_in;
   logic               rsp_valid_ff, rsp_valid_in;
   adrc_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   adrc_pkg::mul_cmd_type mul_cmd;
   adrc_pkg::div_cmd_type div_cmd;
   logic signed [47:0]    mul_res, div_res;
   logic                  mul_done, div_done;
   logic                  mul_wait;

   logic signed [47:0] acc_mag;
   logic signed [48:0] u_raw, lim49, u_clamp, u_abs;
   logic [30:0]        dz_term;
   logic signed [15:0] drive;

   assign req_idx = (WHEELS > 1) ? WIDX'(req_data.wheel) : '0;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         plant_gain_ff <= adrc_pkg::PLANT_GAIN_RST;
         obs_one_ff    <= adrc_pkg::OBS_GAIN_ONE_RST;
         obs_two_ff    <= adrc_pkg::OBS_GAIN_TWO_RST;
         loop_gain_ff  <= adrc_pkg::LOOP_GAIN_RST;
         period_ff     <= adrc_pkg::SAMPLE_PER_RST;
         dead_zone_ff  <= adrc_pkg::DEAD_ZONE_RST;
         limit_ff      <= adrc_pkg::OUTPUT_LIMIT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            adrc_pkg::CSR_PLANT_GAIN:   plant_gain_ff <= csr_wdata;
            adrc_pkg::CSR_OBS_GAIN_ONE: obs_one_ff    <= csr_wdata;
            adrc_pkg::CSR_OBS_GAIN_TWO: obs_two_ff    <= csr_wdata;
            adrc_pkg::CSR_LOOP_GAIN:    loop_gain_ff  <= csr_wdata;
            adrc_pkg::CSR_SAMPLE_PER:   period_ff     <= csr_wdata[15:0];
            adrc_pkg::CSR_DEAD_ZONE:    dead_zone_ff  <= csr_wdata[14:0];
            adrc_pkg::CSR_OUTPUT_LIMIT: limit_ff      <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // per-wheel estimates and last drive
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WHEELS; i++) begin
            z1_mem_ff[i]   <= '0;
            z2_mem_ff[i]   <= '0;
            last_mem_ff[i] <= '0;
         end
      end else begin
         if (we_est) begin
            z1_mem_ff[idx_ff] <= z1n_ff;
            z2_mem_ff[idx_ff] <= z2n_ff;
         end
         if (we_last) begin
            last_mem_ff[idx_ff] <= u_ff;
         end
      end
   end

   // divider operand magnitude, final offset, clamp and truncation toward zero
   always_comb begin
      acc_mag = acc_ff[47] ? -acc_ff : acc_ff;
      dz_term = {dead_zone_ff, 16'd0};
      u_raw   = {div_res[47], div_res};
      if (r_ff > 16'sd0) begin
         u_raw = u_raw + $signed({18'd0, dz_term});
      end else if (r_ff < 16'sd0) begin
         u_raw = u_raw - $signed({18'd0, dz_term});
      end
      lim49   = $signed({18'd0, limit_ff, 16'd0});
      u_clamp = u_raw;
      if (u_raw > lim49) u_clamp = lim49;
      if (u_raw < -lim49) u_clamp = -lim49;
      u_abs   = u_ff[47] ? -{u_ff[47], u_ff} : {u_ff[47], u_ff};
      drive   = u_ff[47] ? -$signed(u_abs[31:16]) : $signed(u_abs[31:16]);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      wheel_in     = wheel_ff;
      idx_in       = idx_ff;
      r_in         = r_ff;
      y_in         = y_ff;
      z1_in        = z1_ff;
      z2_in        = z2_ff;
      last_in      = last_ff;
      e_in         = e_ff;
      acc_in       = acc_ff;
      d1_in        = d1_ff;
      d2_in        = d2_ff;
      z1n_in       = z1n_ff;
      z2n_in       = z2n_ff;
      u_in         = u_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      we_est       = 1'b0;
      we_last      = 1'b0;
      mul_cmd      = '{start: 1'b0, sh16: 1'b0, gain: obs_one_ff, operand: e_ff};
      div_cmd      = '{start: 1'b0, neg: acc_ff[47],
                       num: {1'b0, acc_mag[46:0], 8'd0},
                       den: (plant_gain_ff == 24'd0) ? 24'd1 : plant_gain_ff};
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               wheel_in = req_data.wheel;
               idx_in   = req_idx;
               r_in     = req_data.target_speed;
               y_in     = req_data.measured_speed;
               z1_in    = z1_mem_ff[req_idx];
               z2_in    = z2_mem_ff[req_idx];
               last_in  = last_mem_ff[req_idx];
               state_in = S_ERR;
            end
         end
         S_ERR: begin
            e_in = adrc_pkg::sat48(adrc_pkg::ext50(z1_ff) -
                                   adrc_pkg::ext50({{16{y_ff[15]}}, y_ff, 16'd0}));
            state_in = S_M_BETA1;
         end
         S_M_BETA1: begin
            mul_cmd.start = 1'b1;
            state_in      = S_W_BETA1;
         end
         S_W_BETA1: begin
            if (mul_done) begin
               acc_in = adrc_pkg::sat48(adrc_pkg::ext50(z2_ff) - adrc_pkg::ext50(mul_res));
               state_in = S_M_PLANT;
            end
         end
         S_M_PLANT: begin
            mul_cmd = '{start: 1'b1, sh16: 1'b0, gain: plant_gain_ff, operand: last_ff};
            state_in = S_W_PLANT;
         end
         S_W_PLANT: begin
            if (mul_done) begin
               d1_in = adrc_pkg::sat48(adrc_pkg::ext50(acc_ff) + adrc_pkg::ext50(mul_res));
               state_in = S_M_BETA2;
            end
         end
         S_M_BETA2: begin
            mul_cmd = '{start: 1'b1, sh16: 1'b0, gain: obs_two_ff, operand: e_ff};
            state_in = S_W_BETA2;
         end
         S_W_BETA2: begin
            if (mul_done) begin
               d2_in    = -mul_res;
               state_in = S_M_Z1;
            end
         end
         S_M_Z1: begin
            mul_cmd = '{start: 1'b1, sh16: 1'b1, gain: {8'd0, period_ff}, operand: d1_ff};
            state_in = S_W_Z1;
         end
         S_W_Z1: begin
            if (mul_done) begin
               z1n_in = adrc_pkg::sat48(adrc_pkg::ext50(z1_ff) + adrc_pkg::ext50(mul_res));
               state_in = S_M_Z2;
            end
         end
         S_M_Z2: begin
            mul_cmd = '{start: 1'b1, sh16: 1'b1, gain: {8'd0, period_ff}, operand: d2_ff};
            state_in = S_W_Z2;
         end
         S_W_Z2: begin
            if (mul_done) begin
               z2n_in = adrc_pkg::sat48(adrc_pkg::ext50(z2_ff) + adrc_pkg::ext50(mul_res));
               state_in = S_M_KP;
            end
         end
         S_M_KP: begin
            we_est  = 1'b1;
            mul_cmd = '{start: 1'b1, sh16: 1'b0, gain: loop_gain_ff,
                        operand: adrc_pkg::sat48(
                           adrc_pkg::ext50({{16{r_ff[15]}}, r_ff, 16'd0})
                           - adrc_pkg::ext50(z1n_ff))};
            state_in = S_W_KP;
         end
         S_W_KP: begin
            if (mul_done) begin
               acc_in = adrc_pkg::sat48(adrc_pkg::ext50(mul_res) - adrc_pkg::ext50(z2n_ff));
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            div_cmd.start = 1'b1;
            state_in      = S_W_DIV;
         end
         S_W_DIV: begin
            if (div_done) begin
               u_in     = u_clamp[47:0];
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               we_last      = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{wheel_echo: wheel_ff, drive_out: drive};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      wheel_ff    <= wheel_in;
      idx_ff      <= idx_in;
      r_ff        <= r_in;
      y_ff        <= y_in;
      z1_ff       <= z1_in;
      z2_ff       <= z2_in;
      last_ff     <= last_in;
      e_ff        <= e_in;
      acc_ff      <= acc_in;
      d1_ff       <= d1_in;
      d2_ff       <= d2_in;
      z1n_ff      <= z1n_in;
      z2n_ff      <= z2n_in;
      u_ff        <= u_in;
      rsp_data_ff <= rsp_data_in;
   end

   adrc_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .cmd    (mul_cmd),
      .result (mul_res),
      .done   (mul_done)
   );

   adrc_div u_div (
      .clock  (clock),
      .reset  (reset),
      .cmd    (div_cmd),
      .result (div_res),
      .done   (div_done)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // sequencer waits on a multiplier pass
   assign mul_wait = (state_ff == S_W_BETA1) || (state_ff == S_W_PLANT) ||
                     (state_ff == S_W_BETA2) || (state_ff == S_W_Z1) ||
                     (state_ff == S_W_Z2) || (state_ff == S_W_KP);

   // checks
   `ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && req_ready, !req_ready && state_ff == S_ERR)
   `ASSERT_IMPL(a_mul_done_waits, clock, reset, mul_done, mul_wait)
   `ASSERT_IMPL(a_div_done_waits, clock, reset, div_done, state_ff == S_W_DIV)

endmodule

@@ bench/adrc_speed_loop_unit_test.sv @@
// testbench of the adrc speed loop: drives control ticks, predicts each drive value
// from its own fixed-point model of the observer and control law, checks every beat
// depends on adrc_pkg and adrc_speed_loop_unit
`timescale 1ns / 100ps

module adrc_speed_loop_unit_test;

   localparam int NWHEELS = 2;
   localparam longint MAG48 = 64'sh7FFF_FFFF_FFFF;
   // index with no register behind it
   localparam logic [2:0] CSR_UNUSED = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   adrc_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   adrc_pkg::rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [2:0] csr_index = '0;
   logic [23:0] csr_wdata = '0;

   adrc_speed_loop_unit #(.WHEELS(NWHEELS)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // model copy of registers and per-wheel estimates
   logic [23:0] b0_gain, beta1_gain, beta2_gain, kp_gain;
   logic [15:0] step_time;
   logic [14:0] dz_offset, drive_limit;
   longint z1_est[NWHEELS], z2_est[NWHEELS], u_prev[NWHEELS];

   adrc_pkg::req_type tick_queue[$];
   adrc_pkg::rsp_type drive_expect[$];
   int errors = 0;
   int hold_off = 0;
   int gap_left = 0;
   bit drain_pause = 1'b0;
   logic req_ready_seen = 1'b0;

   function automatic longint clamp48(longint v);
      if (v > MAG48) return MAG48;
      if (v < -MAG48) return -MAG48;
      return v;
   endfunction

   // exact product, shifted back with magnitude truncation, saturated
   function automatic longint scaled_product(longint a, logic [23:0] g, int sh);
      logic [127:0] m;
      bit neg;
      neg = a < 0;
      m = (neg ? -a : a);
      m = (m * g) >> sh;
      if (m > MAG48) m = MAG48;
      return neg ? -longint'(m) : longint'(m);
   endfunction

   task automatic reset_model();
      b0_gain = adrc_pkg::PLANT_GAIN_RST; beta1_gain = adrc_pkg::OBS_GAIN_ONE_RST;
      beta2_gain = adrc_pkg::OBS_GAIN_TWO_RST; kp_gain = adrc_pkg::LOOP_GAIN_RST;
      step_time = adrc_pkg::SAMPLE_PER_RST; dz_offset = adrc_pkg::DEAD_ZONE_RST;
      drive_limit = adrc_pkg::OUTPUT_LIMIT_RST;
      for (int i = 0; i < NWHEELS; i++) begin
         z1_est[i] = 0; z2_est[i] = 0; u_prev[i] = 0;
      end
   endtask

   // one observer update plus control law for one tick
   function automatic adrc_pkg::rsp_type control_tick(adrc_pkg::req_type t);
      int w;
      longint r, y, z1, z2, e, d1, d2, u0, v, u, lim, b0;
      adrc_pkg::rsp_type res;
      w = int'(t.wheel) % NWHEELS;
      r = t.target_speed;
      y = t.measured_speed;
      z1 = z1_est[w];
      z2 = z2_est[w];
      e = clamp48(z1 - y * 65536);
      d1 = clamp48(clamp48(z2 - scaled_product(e, beta1_gain, 8))
                   + scaled_product(u_prev[w], b0_gain, 8));
      d2 = -scaled_product(e, beta2_gain, 8);
      z1 = clamp48(z1 + scaled_product(d1, {8'd0, step_time}, 16));
      z2 = clamp48(z2 + scaled_product(d2, {8'd0, step_time}, 16));
      z1_est[w] = z1;
      z2_est[w] = z2;
      u0 = scaled_product(clamp48(r * 65536 - z1), kp_gain, 8);
      v = clamp48(u0 - z2);
      b0 = (b0_gain != 0) ? longint'(b0_gain) : 1;
      u = clamp48((v * 256) / b0);
      if (r > 0) u += longint'(dz_offset) * 65536;
      else if (r < 0) u -= longint'(dz_offset) * 65536;
      lim = longint'(drive_limit) * 65536;
      if (u > lim) u = lim;
      if (u < -lim) u = -lim;
      u_prev[w] = u;
      res.wheel_echo = t.wheel;
      res.drive_out = 16'(u / 65536);
      return res;
   endfunction

   task automatic csr_write(logic [2:0] idx, logic [23:0] val);
      @(negedge clock);
      csr_wr_en = 1'b1; csr_index = idx; csr_wdata = val;
      case (idx)
         adrc_pkg::CSR_PLANT_GAIN:   b0_gain = val;
         adrc_pkg::CSR_OBS_GAIN_ONE: beta1_gain = val;
         adrc_pkg::CSR_OBS_GAIN_TWO: beta2_gain = val;
         adrc_pkg::CSR_LOOP_GAIN:    kp_gain = val;
         adrc_pkg::CSR_SAMPLE_PER:   step_time = val[15:0];
         adrc_pkg::CSR_DEAD_ZONE:    dz_offset = val[14:0];
         adrc_pkg::CSR_OUTPUT_LIMIT: drive_limit = val[14:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // wait for all queued ticks and results, then let the sequencer settle
   task automatic wait_idle();
      while (tick_queue.size() != 0 || req_valid || drive_expect.size() != 0)
         @(posedge clock);
      repeat (120) @(negedge clock);
   endtask

   function automatic adrc_pkg::req_type make_tick(logic w, logic [15:0] r, logic [15:0] y);
      adrc_pkg::req_type t;
      t.wheel = w; t.target_speed = r; t.measured_speed = y;
      return t;
   endfunction

   function automatic logic [15:0] rand_speed();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(0, 1) ? $urandom_range(0, 40) : -$urandom_range(0, 40));
         default: return 16'($urandom);
      endcase
   endfunction

   // predictor: expected beat computed at each accepted tick
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         drive_expect.push_back(control_tick(req_data));
      end
   end

   // acceptance seen at the last rising edge
   always @(posedge clock) begin
      req_ready_seen <= req_valid && req_ready;
   end

   // driver: offers ticks from the queue with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_ready_seen) begin
         // still waiting for acceptance
      end else begin
         if (gap_left > 0 || drain_pause) begin
            req_valid <= 1'b0;
            if (gap_left > 0) gap_left <= gap_left - 1;
         end else if (tick_queue.size() != 0) begin
            req_valid <= 1'b1;
            req_data <= tick_queue.pop_front();
            gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                        : (($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus a long forced hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_off > 0) begin
         rsp_ready <= 1'b0;
         hold_off <= hold_off - 1;
      end else begin
         case ($urandom_range(0, 19))
            0: begin
               rsp_ready <= 1'b0;
               hold_off <= $urandom_range(20, 150);
            end
            1, 2, 3: rsp_ready <= 1'b0;
            default: rsp_ready <= 1'b1;
         endcase
      end
   end

   // monitor: compare each result beat with the oldest expectation
   always @(posedge clock) begin
      adrc_pkg::rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (drive_expect.size() == 0) begin
            $error("unexpected result beat: wheel_echo %0d drive_out %0d",
                   rsp_data.wheel_echo, rsp_data.drive_out);
            errors++;
         end else begin
            exp_rsp = drive_expect.pop_front();
            if (rsp_data.wheel_echo !== exp_rsp.wheel_echo) begin
               $error("wheel_echo expected %0d actual %0d",
                      exp_rsp.wheel_echo, rsp_data.wheel_echo);
               errors++;
            end
            if (rsp_data.drive_out !== exp_rsp.drive_out) begin
               $error("drive_out expected %0d actual %0d",
                      exp_rsp.drive_out, rsp_data.drive_out);
               errors++;
            end
         end
      end
   end

   // run limit
   initial begin
      #40ms;
      $display("adrc_speed_loop_unit_test: errors");
      $finish;
   end

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++)
         tick_queue.push_back(make_tick(1'($urandom), rand_speed(), rand_speed()));
   endtask

   initial begin
      logic [15:0] edge_vals[4];
      edge_vals = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
      reset_model();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes on both wheels at reset settings
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j += 3)
            tick_queue.push_back(make_tick(1'(i & 1), edge_vals[i], edge_vals[j]));
      tick_queue.push_back(make_tick(1'b0, 16'd100, 16'd0));
      tick_queue.push_back(make_tick(1'b1, -16'sd100, 16'd5));
      wait_idle();

      // zero plant gain, zero sample period, dead zone, then zero limit and a write to an unused index
      csr_write(adrc_pkg::CSR_PLANT_GAIN, 24'd0);
      csr_write(adrc_pkg::CSR_SAMPLE_PER, 24'd0);
      csr_write(adrc_pkg::CSR_DEAD_ZONE, 24'd300);
      tick_queue.push_back(make_tick(1'b0, 16'd10, 16'd3));
      tick_queue.push_back(make_tick(1'b1, -16'sd10, 16'd3));
      tick_queue.push_back(make_tick(1'b0, 16'd0, 16'd3));
      wait_idle();
      csr_write(adrc_pkg::CSR_OUTPUT_LIMIT, 24'd0);
      csr_write(CSR_UNUSED, 24'hFFFFFF);
      tick_queue.push_back(make_tick(1'b1, 16'h7FFF, 16'h8000));
      tick_queue.push_back(make_tick(1'b0, 16'h8000, 16'h7FFF));
      wait_idle();

      // full-scale gains, sample period, dead zone and limit
      csr_write(adrc_pkg::CSR_PLANT_GAIN, 24'hFFFFFF);
      csr_write(adrc_pkg::CSR_OBS_GAIN_ONE, 24'hFFFFFF);
      csr_write(adrc_pkg::CSR_OBS_GAIN_TWO, 24'hFFFFFF);
      csr_write(adrc_pkg::CSR_LOOP_GAIN, 24'hFFFFFF);
      csr_write(adrc_pkg::CSR_SAMPLE_PER, 24'h00FFFF);
      csr_write(adrc_pkg::CSR_DEAD_ZONE, 24'h007FFF);
      csr_write(adrc_pkg::CSR_OUTPUT_LIMIT, 24'h007FFF);
      random_phase(150);
      wait_idle();

      // long receiver hold-off while ticks keep coming
      @(posedge clock);
      hold_off = 800;
      random_phase(30);
      wait_idle();

      // sender pauses mid-stream until every expected beat has come
      random_phase(40);
      repeat (400) @(negedge clock);
      drain_pause = 1'b1;
      while (req_valid || drive_expect.size() != 0)
         @(posedge clock);
      @(negedge clock);
      drain_pause = 1'b0;
      wait_idle();

      // a few random register settings
      for (int p = 0; p < 4; p++) begin
         csr_write(adrc_pkg::CSR_PLANT_GAIN, 24'($urandom_range(1, 24'hFFFFFF)));
         csr_write(adrc_pkg::CSR_OBS_GAIN_ONE, 24'($urandom));
         csr_write(adrc_pkg::CSR_OBS_GAIN_TWO, 24'($urandom));
         csr_write(adrc_pkg::CSR_LOOP_GAIN, 24'($urandom_range(0, 20000)));
         csr_write(adrc_pkg::CSR_SAMPLE_PER, 24'($urandom_range(1, 3000)));
         csr_write(adrc_pkg::CSR_DEAD_ZONE, 24'($urandom_range(0, 500)));
         csr_write(adrc_pkg::CSR_OUTPUT_LIMIT, 24'($urandom_range(0, 32767)));
         random_phase(150);
         wait_idle();
      end

      // unit plant gain, zero observer and loop gains, default dead zone and limit, sample period of one
      csr_write(adrc_pkg::CSR_PLANT_GAIN, 24'd1);
      csr_write(adrc_pkg::CSR_OBS_GAIN_ONE, 24'd0);
      csr_write(adrc_pkg::CSR_OBS_GAIN_TWO, 24'd0);
      csr_write(adrc_pkg::CSR_LOOP_GAIN, 24'd0);
      csr_write(adrc_pkg::CSR_SAMPLE_PER, 24'd1);
      csr_write(adrc_pkg::CSR_DEAD_ZONE, 24'd0);
      csr_write(adrc_pkg::CSR_OUTPUT_LIMIT, 24'd10000);
      random_phase(40);
      wait_idle();

      if (errors == 0) begin
         $display("adrc_speed_loop_unit_test: clean");
      end else begin
         $display("adrc_speed_loop_unit_test: errors");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+sv
sv/adrc_pkg.sv
sv/adrc_mul.sv
sv/adrc_div.sv
sv/adrc_speed_loop_unit.sv
bench/adrc_speed_loop_unit_test.sv
